// ----- src/qafs_pkg.sv -----
// Shared types and constants for the quote aware field splitter.
package qafs_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE     = 1'b1;

   localparam logic [7:0] DELIMITER_RESET = 8'd9;
   localparam logic [7:0] QUOTE_RESET     = 8'd34;
   localparam logic [7:0] SPACE_CHAR      = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_last;
   } in_item_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] out_char;
      logic [7:0] spaces_before;
      logic       field_end;
      logic       line_end;
      logic       space_overflow;
   } result_type;

   typedef struct packed {
      logic [7:0] delimiter_char;
      logic [7:0] quote_char;
   } csr_type;

endpackage

// ----- src/qafs_in_stage.sv -----
// Input register stage that holds one accepted item for the tokenizer.
module qafs_in_stage
   import qafs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   output logic        up_ready,
   input  in_item_type up_item,
   output logic        down_valid,
   input  logic        down_ready,
   output in_item_type down_item
);

   logic        valid_ff, valid_in;
   in_item_type item_ff, item_in;
   logic        up_fire;

   always_comb begin
      up_ready = !valid_ff || down_ready;
      up_fire  = up_valid && up_ready;
      if (up_fire) begin
         valid_in = 1'b1;
         item_in  = up_item;
      end else begin
         valid_in = valid_ff && !down_ready;
         item_in  = item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign down_valid = valid_ff;
   assign down_item  = item_ff;

endmodule

// ----- src/qafs_tokenizer.sv -----
// Field state, per-character decision logic and the result register.
module qafs_tokenizer
   import qafs_pkg::*;
#(
   parameter int SPACE_COUNT_BITS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  csr_type     csr,
   input  logic        in_valid,
   output logic        in_ready,
   input  in_item_type in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_result
);

   localparam int CNT_W = (SPACE_COUNT_BITS > 8) ? 8 : SPACE_COUNT_BITS;
   localparam logic [CNT_W-1:0] SPACE_LIMIT = {CNT_W{1'b1}};

   logic             in_quotes_ff, in_quotes_in;
   logic             has_content_ff, has_content_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic             held_ovf_ff, held_ovf_in;
   logic             out_valid_ff, out_valid_in;
   result_type       result_ff, result_in, calc;
   logic             advance;
   logic             quotes_next;

   always_comb begin
      in_ready = !out_valid_ff || out_ready;
      advance  = in_valid && in_ready;

      quotes_next    = in_quotes_ff ^ (in_item.in_byte == csr.quote_char);
      has_content_in = has_content_ff;
      held_in        = held_ff;
      held_ovf_in    = held_ovf_ff;
      calc           = '0;
      calc.line_end  = in_item.line_last;

      if (in_item.in_byte == csr.delimiter_char && !quotes_next) begin
         calc.space_overflow = held_ovf_ff;
         calc.field_end      = has_content_ff;
         has_content_in      = 1'b0;
         held_in             = '0;
         held_ovf_in         = 1'b0;
      end else begin
         if (in_item.in_byte == SPACE_CHAR) begin
            if (has_content_ff) begin
               if (held_ff != SPACE_LIMIT) begin
                  held_in = CNT_W'(held_ff + 1'b1);
               end else begin
                  held_ovf_in = 1'b1;
               end
            end
         end else begin
            calc.char_valid    = 1'b1;
            calc.out_char      = in_item.in_byte;
            calc.spaces_before = 8'(held_ff);
            held_in            = '0;
            has_content_in     = 1'b1;
         end
         calc.space_overflow = held_ovf_in;
         calc.field_end      = in_item.line_last && has_content_in;
      end

      in_quotes_in = quotes_next;
      if (in_item.line_last) begin
         in_quotes_in   = 1'b0;
         has_content_in = 1'b0;
         held_in        = '0;
         held_ovf_in    = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         result_in    = calc;
      end else begin
         out_valid_in = out_valid_ff && !out_ready;
         result_in    = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff   <= 1'b0;
         has_content_ff <= 1'b0;
         held_ff        <= '0;
         held_ovf_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            in_quotes_ff   <= in_quotes_in;
            has_content_ff <= has_content_in;
            held_ff        <= held_in;
            held_ovf_ff    <= held_ovf_in;
         end
      end
      result_ff <= result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

// ----- src/quote_aware_field_splitter_unit.sv -----
// Top level of the quote aware field splitter: ports, registers and stage wiring.
//
// The req channel carries one character of a text line per item, with tlast set
// on the character that ends the line. The rsp channel returns exactly one
// result item per input item, in order: the content character with the count of
// inner spaces to insert before it, a field end flag when a non-empty field
// closes, a space overflow flag and a copy of the line end in tlast.
// The csr port writes the delimiter (index 0) and the quote character (index 1);
// the user writes it only while the block is idle; the block does not enforce it.
// An accepted item sits in the input register, is then decided and loaded into
// the result register and leaves on rsp from there. One item is accepted every
// cycle while rsp does not stall; the tokenizer's field state is updated in
// the same cycle its result is registered, so consecutive characters flow back
// to back.
// When the receiver stalls, the result register holds its item. req_tready
// follows rsp_tready through both stages, so the input stops in the same cycle
// unless the input register is empty, in which case it takes one more item first.
// Reset clears the quoted flag, the field state and both stage valids, and
// loads the delimiter with a tab and the quote with a double quote.
module quote_aware_field_splitter_unit
   import qafs_pkg::*;
#(
   parameter int SPACE_COUNT_BITS = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] in_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,  // [7:0] out_char, [15:8] spaces_before
   output logic [2:0]             rsp_tuser,  // [0] char_valid, [1] field_end,
                                              // [2] space_overflow
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type     csr_ff, csr_in;
   in_item_type up_item, stage_item;
   logic        stage_valid, stage_ready;
   result_type  result;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DELIMITER: csr_in.delimiter_char = csr_wdata;
            CSR_QUOTE:     csr_in.quote_char     = csr_wdata;
            default:       csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.delimiter_char <= DELIMITER_RESET;
         csr_ff.quote_char     <= QUOTE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign up_item.in_byte   = req_tdata;
   assign up_item.line_last = req_tlast;

   qafs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .up_item    (up_item),
      .down_valid (stage_valid),
      .down_ready (stage_ready),
      .down_item  (stage_item)
   );

   qafs_tokenizer #(
      .SPACE_COUNT_BITS (SPACE_COUNT_BITS)
   ) u_tokenizer (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .in_valid   (stage_valid),
      .in_ready   (stage_ready),
      .in_item    (stage_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {result.spaces_before, result.out_char};
   assign rsp_tuser = {result.space_overflow, result.field_end, result.char_valid};
   assign rsp_tlast = result.line_end;

endmodule

// ----- tb/tb_quote_aware_field_splitter_unit.sv -----
// Testbench for the quote aware field splitter: directed and random lines checked against a field predictor.
`timescale 1ns / 1ps

module tb_quote_aware_field_splitter_unit;
   import qafs_pkg::*;

   localparam int SPACE_BITS     = 8;
   localparam int SPACE_LIMIT    = ((1 << SPACE_BITS) - 1) > 255 ? 255 : ((1 << SPACE_BITS) - 1);
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 6;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'd0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DELIMITER;
   logic [CSR_DATA_W-1:0]  csr_wdata  = 8'd0;

   quote_aware_field_splitter_unit #(
      .SPACE_COUNT_BITS(SPACE_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   in_item_type pending_chars[$];
   result_type  expected_results[$];

   logic       sender_idle = 1'b1;
   logic       rsp_stall   = 1'b1;
   int         burst_left  = 0;
   int         gap_left    = 0;
   logic [15:0] ready_pattern = 16'hFFFF;
   int         ready_phase = 0;

   logic [7:0] cfg_delim = DELIMITER_RESET;
   logic [7:0] cfg_quote = QUOTE_RESET;
   logic       fld_in_quotes;
   logic       fld_has_content;
   logic [7:0] fld_held_spaces;
   logic       fld_held_ovf;

   int mismatch_count = 0;
   int chars_sent     = 0;
   int fields_closed  = 0;
   int saturations    = 0;
   int settings_used  = 1;
   int idle_cycles    = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
         req_tlast  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_chars.size() > 0) begin
            in_item_type it;
            it = pending_chars.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.in_byte;
            req_tlast  <= it.line_last;
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = sender_idle ? $urandom_range(0, 9) : 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_phase = 0;
      end else begin
         if (ready_phase == 0) begin
            if (!rsp_stall || $urandom_range(0, 3) == 0) begin
               ready_pattern = 16'hFFFF;
            end else begin
               ready_pattern = 16'($urandom);
            end
         end
         rsp_tready <= ready_pattern[ready_phase];
         ready_phase = (ready_phase + 1) % 16;
      end
   end

   task automatic clear_field();
      fld_has_content = 1'b0;
      fld_held_spaces = 8'd0;
      fld_held_ovf    = 1'b0;
   endtask

   task automatic split_char(input in_item_type it, output result_type r);
      logic [7:0] b;
      b = it.in_byte;
      r = '0;
      if (b == cfg_quote) begin
         fld_in_quotes = !fld_in_quotes;
      end
      if (b == cfg_delim && !fld_in_quotes) begin
         r.space_overflow = fld_held_ovf;
         r.field_end      = fld_has_content;
         clear_field();
      end else begin
         if (b == SPACE_CHAR) begin
            if (fld_has_content) begin
               if (fld_held_spaces < SPACE_LIMIT) begin
                  fld_held_spaces = fld_held_spaces + 8'd1;
               end else begin
                  fld_held_ovf = 1'b1;
               end
            end
         end else begin
            r.char_valid    = 1'b1;
            r.out_char      = b;
            r.spaces_before = fld_held_spaces;
            fld_held_spaces = 8'd0;
            fld_has_content = 1'b1;
         end
         r.space_overflow = fld_held_ovf;
         if (it.line_last) begin
            r.field_end = fld_has_content;
            clear_field();
         end
      end
      if (it.line_last) begin
         fld_in_quotes = 1'b0;
         clear_field();
      end
      r.line_end = it.line_last;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_delim     = DELIMITER_RESET;
         cfg_quote     = QUOTE_RESET;
         fld_in_quotes = 1'b0;
         clear_field();
         idle_cycles   = 0;
      end else begin
         logic       progress;
         result_type got;
         result_type want;
         progress = csr_we;
         if (csr_we) begin
            case (csr_index)
               CSR_DELIMITER: cfg_delim = csr_wdata;
               CSR_QUOTE:     cfg_quote = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            progress           = 1'b1;
            got.char_valid     = rsp_tuser[0];
            got.out_char       = rsp_tdata[7:0];
            got.spaces_before  = rsp_tdata[15:8];
            got.field_end      = rsp_tuser[1];
            got.line_end       = rsp_tlast;
            got.space_overflow = rsp_tuser[2];
            if (expected_results.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("unexpected result item: valid=%0d char=%h sp=%0d fend=%0d lend=%0d ovf=%0d",
                           got.char_valid, got.out_char, got.spaces_before,
                           got.field_end, got.line_end, got.space_overflow);
               end
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected valid=%0d char=%h sp=%0d fend=%0d lend=%0d ovf=%0d",
                              want.char_valid, want.out_char, want.spaces_before,
                              want.field_end, want.line_end, want.space_overflow);
                     $display("          got      valid=%0d char=%h sp=%0d fend=%0d lend=%0d ovf=%0d",
                              got.char_valid, got.out_char, got.spaces_before,
                              got.field_end, got.line_end, got.space_overflow);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            in_item_type it;
            progress     = 1'b1;
            it.in_byte   = req_tdata;
            it.line_last = req_tlast;
            split_char(it, want);
            expected_results.push_back(want);
            chars_sent = chars_sent + 1;
            if (want.field_end) fields_closed = fields_closed + 1;
            if (want.space_overflow && want.field_end) saturations = saturations + 1;
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic push_char(input logic [7:0] b, input logic last);
      in_item_type it;
      it.in_byte   = b;
      it.line_last = last;
      pending_chars.push_back(it);
   endtask

   task automatic push_line(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (!(pending_chars.size() == 0 && !req_tvalid && expected_results.size() == 0)) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_chars(input logic [7:0] delim, input logic [7:0] quote);
      wait_idle();
      write_reg(CSR_DELIMITER, delim);
      write_reg(CSR_QUOTE, quote);
      settings_used = settings_used + 1;
   endtask

   // Lines are mostly letters, spaces, delimiters and quotes, with some raw bytes as noise.
   task automatic random_lines(input logic [7:0] delim, input logic [7:0] quote, input int n);
      int         count;
      int         len;
      int         pick;
      int         run;
      logic [7:0] b;
      count = 0;
      while (count < n) begin
         len = $urandom_range(1, 24);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 199) == 0) begin
               run = $urandom_range(16, 270);
               repeat (run) push_char(SPACE_CHAR, 1'b0);
               count = count + run;
            end
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
               b = SPACE_CHAR;
            end else if (pick < 40) begin
               b = delim;
            end else if (pick < 50) begin
               b = quote;
            end else if (pick < 92) begin
               b = 8'($urandom_range(97, 122));
            end else begin
               b = 8'($urandom_range(1, 255));
            end
            push_char(b, i == len - 1);
         end
         count = count + len;
      end
   endtask

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      sender_idle = 1'b1;
      rsp_stall   = 1'b1;
      push_line("  a  b \t\tc");
      push_line("\"x\ty\"");
      push_line("\"ab");
      push_line("\tq");
      push_line("ab\t");
      push_line(" ");
      push_char(8'h01, 1'b0);
      push_char(8'hFF, 1'b1);

      set_chars(8'd44, 8'd34);
      random_lines(8'd44, 8'd34, 200);

      set_chars(8'd39, 8'd39);
      sender_idle = 1'b0;
      push_line("x'y z'w");
      random_lines(8'd39, 8'd39, 180);

      set_chars(SPACE_CHAR, 8'd255);
      sender_idle = 1'b1;
      rsp_stall   = 1'b0;
      random_lines(SPACE_CHAR, 8'd255, 180);

      set_chars(8'd1, 8'd255);
      sender_idle = 1'b0;
      random_lines(8'd1, 8'd255, 180);

      set_chars(8'd255, 8'd1);
      sender_idle = 1'b1;
      rsp_stall   = 1'b1;
      random_lines(8'd255, 8'd1, 180);

      set_chars(DELIMITER_RESET, QUOTE_RESET);
      push_char("a", 1'b0);
      repeat (300) push_char(SPACE_CHAR, 1'b0);
      push_char("b", 1'b0);
      repeat (10) push_char(SPACE_CHAR, 1'b0);
      push_char(DELIMITER_RESET, 1'b0);
      push_char("c", 1'b0);
      repeat (SPACE_LIMIT) push_char(SPACE_CHAR, 1'b0);
      push_char("d", 1'b1);
      random_lines(DELIMITER_RESET, QUOTE_RESET, 80);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatch_count = mismatch_count + expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end
      $display("Sent %0d characters under %0d delimiter and quote settings.",
               chars_sent, settings_used);
      $display("Saw %0d closed fields, %0d of them with saturated spaces; %0d mismatches.",
               fields_closed, saturations, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
